/* rtl/lsd_pkg.sv */
package lsd_pkg;

    localparam int HistDepth = 5;
    localparam int CntW      = $clog2(HistDepth + 1);

    localparam int AdcW      = 12;
    localparam int TimeW     = 16;
    localparam int CountW    = 8;
    localparam int SDataW    = 32;
    localparam int SUserW    = 8;
    localparam int MDataW    = 24;

    localparam logic [AdcW-1:0] AdcMax     = 12'h3FF;
    localparam logic [AdcW-1:0] ButtonHi   = 12'd40;
    localparam logic [AdcW-1:0] OffLo      = 12'd368;
    localparam logic [AdcW-1:0] OffHi      = 12'd450;
    localparam logic [AdcW-1:0] ManualLo   = 12'd573;
    localparam logic [AdcW-1:0] ManualHi   = 12'd655;
    localparam logic [AdcW-1:0] AutoLo     = 12'd778;
    localparam logic [AdcW-1:0] AutoHi     = 12'd860;
    localparam logic [AdcW-1:0] UnconnLo   = 12'd982;

    localparam logic [TimeW-1:0] LongPressReset = 16'd300;

    typedef logic [CntW-1:0] hist_cnt_t;

    typedef enum logic [2:0] {
        CL_UNKNOWN = 3'd0,
        CL_OFF     = 3'd1,
        CL_AUTO    = 3'd2,
        CL_MANUAL  = 3'd3,
        CL_UNCONN  = 3'd4,
        CL_BUTTON  = 3'd5,
        CL_INVALID = 3'd6
    } cls_t;

    typedef enum logic [2:0] {
        MODE_UNKNOWN = 3'd0,
        MODE_OFF     = 3'd1,
        MODE_AUTO    = 3'd2,
        MODE_MANUAL  = 3'd3,
        MODE_UNCONN  = 3'd4,
        MODE_INVALID = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        BTN_UNKNOWN  = 2'd0,
        BTN_RELEASED = 2'd1,
        BTN_SHORT    = 2'd2,
        BTN_LONG     = 2'd3
    } btn_t;

    typedef enum logic [1:0] {
        NTF_OFF    = 2'd0,
        NTF_AUTO   = 2'd1,
        NTF_MANUAL = 2'd2,
        NTF_UNCONN = 2'd3
    } ntf_t;

    typedef struct packed {
        logic             sample_ok;
        logic [AdcW-1:0]  adc_value;
        logic [TimeW-1:0] now_time;
        logic             restart;
    } in_item_t;

    typedef struct packed {
        logic confirm;
        cls_t cls;
    } deb_t;

    typedef struct packed {
        ntf_t              notify_code;
        logic              notify_valid;
        logic              ok_report;
        logic [CountW-1:0] press_change_count;
        btn_t              button_state;
        mode_t             switch_mode;
    } result_t;

endpackage

/* rtl/ladder_switch_debounce_decoder.sv */
// Resistor-ladder switch decoder: each stream transaction carries one ADC sample, which is
// sorted into a voltage window, debounced over five equal classes in a row, and fed to the
// button press machine and the mode tracker; every sample yields exactly one result.
// A sample is taken every clock cycle unless the result register stalls; it passes the
// input register, then the result register. The debounce count and button/mode update
// loop sets the sustained rate. long_press_time resets to 300 and is written over the cfg
// channel; the user must do so only while the block idles; the block does not enforce it.
module ladder_switch_debounce_decoder
    import lsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // adc_value[11:0], now_time[27:12], restart[28], zero[31:29]
    input  logic [SDataW-1:0] s_tdata,
    // sample_ok[0], zero[7:1]
    input  logic [SUserW-1:0] s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // switch_mode[2:0], button_state[4:3], press_change_count[12:5], ok_report[13],
    // notify_valid[14], notify_code[16:15], zero[23:17]
    output logic [MDataW-1:0] m_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TimeW-1:0]  cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    in_item_t          in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [MDataW-1:0] out_data_reg;
    logic [MDataW-1:0] out_data_next;
    logic [TimeW-1:0]  lpt_reg;
    logic              advance;
    logic              s_take;
    cls_t              cls;
    deb_t              deb;
    result_t           res;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
        out_data_next = MDataW'({res.notify_code, res.notify_valid, res.ok_report,
                                 res.press_change_count, res.button_state,
                                 res.switch_mode});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lpt_reg       <= LongPressReset;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                lpt_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg.sample_ok <= s_tuser[0];
            in_item_reg.adc_value <= s_tdata[AdcW-1:0];
            in_item_reg.now_time  <= s_tdata[AdcW+TimeW-1:AdcW];
            in_item_reg.restart   <= s_tdata[AdcW+TimeW];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    lsd_classify u_classify (
        .adc_value (in_item_reg.adc_value),
        .cls       (cls)
    );

    lsd_debounce u_debounce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .restart   (in_item_reg.restart),
        .sample_ok (in_item_reg.sample_ok),
        .cls       (cls),
        .deb       (deb)
    );

    lsd_tracker u_tracker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .restart         (in_item_reg.restart),
        .now_time        (in_item_reg.now_time),
        .long_press_time (lpt_reg),
        .deb             (deb),
        .res             (res)
    );

    a_code_matches_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> m_tdata[2:0] == {1'b0, m_tdata[16:15]} + 3'd1)
        else $error("notification code disagrees with switch mode");

    a_ok_only_on_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[13] |-> m_tdata[14] && m_tdata[16:15] != NTF_UNCONN)
        else $error("module OK reported without a mode notification");

    a_quiet_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[14] |-> m_tdata[16:15] == NTF_OFF)
        else $error("notification code set without a notification");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the result register is empty");

endmodule

/* rtl/lsd_classify.sv */
module lsd_classify
    import lsd_pkg::*;
(
    input  logic [AdcW-1:0] adc_value,
    output cls_t            cls
);

    always_comb begin
        if (adc_value > AdcMax) begin
            cls = CL_INVALID;
        end else if (adc_value <= ButtonHi) begin
            cls = CL_BUTTON;
        end else if (adc_value < OffLo) begin
            cls = CL_INVALID;
        end else if (adc_value <= OffHi) begin
            cls = CL_OFF;
        end else if (adc_value < ManualLo) begin
            cls = CL_INVALID;
        end else if (adc_value <= ManualHi) begin
            cls = CL_MANUAL;
        end else if (adc_value < AutoLo) begin
            cls = CL_INVALID;
        end else if (adc_value <= AutoHi) begin
            cls = CL_AUTO;
        end else if (adc_value < UnconnLo) begin
            cls = CL_INVALID;
        end else begin
            cls = CL_UNCONN;
        end
    end

endmodule

/* rtl/lsd_debounce.sv */
module lsd_debounce
    import lsd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic advance,
    input  logic restart,
    input  logic sample_ok,
    input  cls_t cls,
    output deb_t deb
);

    cls_t      hist_reg  [HistDepth-1];
    cls_t      hist_next [HistDepth-1];
    hist_cnt_t cnt_reg;
    hist_cnt_t cnt_next;
    hist_cnt_t cnt_eff;
    hist_cnt_t cnt_inc;
    logic      same;
    logic      confirm;

    always_comb begin
        cnt_eff = restart ? '0 : cnt_reg;
        cnt_inc = (cnt_eff < CntW'(HistDepth)) ? cnt_eff + 1'b1 : cnt_eff;
        same = 1'b1;
        for (int i = 0; i < HistDepth - 1; i++) begin
            if (hist_reg[i] != cls) begin
                same = 1'b0;
            end
        end
        confirm = sample_ok && (cnt_inc == CntW'(HistDepth)) && same;
    end

    always_comb begin
        if (!sample_ok || confirm) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt_inc;
        end
        hist_next = hist_reg;
        if (sample_ok && !confirm) begin
            hist_next[0] = cls;
            for (int i = 1; i < HistDepth - 1; i++) begin
                hist_next[i] = hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (advance) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hist_reg <= hist_next;
        end
    end

    assign deb.confirm = confirm;
    assign deb.cls     = cls;

endmodule

/* rtl/lsd_tracker.sv */
module lsd_tracker
    import lsd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             restart,
    input  logic [TimeW-1:0] now_time,
    input  logic [TimeW-1:0] long_press_time,
    input  deb_t             deb,
    output result_t          res
);

    mode_t             mode_reg;
    mode_t             mode_next;
    mode_t             mode_eff;
    btn_t              phase_reg;
    btn_t              phase_next;
    btn_t              phase_eff;
    logic [TimeW-1:0]  start_reg;
    logic [TimeW-1:0]  start_next;
    logic [TimeW-1:0]  start_eff;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic [CountW-1:0] count_eff;
    logic              pending_reg;
    logic              pending_next;
    logic              pending_eff;
    logic [TimeW-1:0]  elapsed;
    logic              long_due;
    logic              is_button;
    logic              is_mode;
    logic              is_notice;
    logic              notify;
    ntf_t              code;

    always_comb begin
        mode_eff    = restart ? MODE_UNKNOWN : mode_reg;
        phase_eff   = restart ? BTN_UNKNOWN : phase_reg;
        start_eff   = restart ? '0 : start_reg;
        count_eff   = restart ? '0 : count_reg;
        pending_eff = restart ? 1'b1 : pending_reg;
        elapsed     = now_time - start_eff;
        long_due    = elapsed >= long_press_time;
        is_button   = deb.cls == CL_BUTTON;
    end

    always_comb begin
        phase_next = phase_eff;
        if (deb.confirm) begin
            if (is_button) begin
                unique case (phase_eff)
                    BTN_RELEASED: phase_next = BTN_SHORT;
                    BTN_SHORT:    phase_next = long_due ? BTN_LONG : BTN_SHORT;
                    default:      phase_next = phase_eff;
                endcase
            end else begin
                phase_next = BTN_RELEASED;
            end
        end
    end

    always_comb begin
        start_next = start_eff;
        count_next = count_eff;
        mode_next  = mode_eff;
        if (deb.confirm) begin
            if (is_button) begin
                if (phase_eff == BTN_RELEASED) begin
                    start_next = now_time;
                    count_next = count_eff + 1'b1;
                end else if (phase_eff == BTN_SHORT && long_due) begin
                    start_next = '0;
                end
            end else begin
                start_next = '0;
                if (phase_eff != BTN_RELEASED) begin
                    count_next = count_eff + 1'b1;
                end
                mode_next = (deb.cls == CL_INVALID) ? MODE_INVALID : mode_t'(deb.cls);
            end
        end
    end

    always_comb begin
        is_mode   = 1'b0;
        is_notice = 1'b1;
        code      = NTF_OFF;
        unique case (mode_next)
            MODE_OFF: begin
                is_mode = 1'b1;
                code    = NTF_OFF;
            end
            MODE_AUTO: begin
                is_mode = 1'b1;
                code    = NTF_AUTO;
            end
            MODE_MANUAL: begin
                is_mode = 1'b1;
                code    = NTF_MANUAL;
            end
            MODE_UNCONN: begin
                code = NTF_UNCONN;
            end
            default: begin
                is_notice = 1'b0;
            end
        endcase
        notify       = (mode_next != mode_eff) && is_notice;
        pending_next = pending_eff && !notify;
    end

    always_comb begin
        res.switch_mode        = mode_next;
        res.button_state       = phase_next;
        res.press_change_count = count_next;
        res.ok_report          = notify && pending_eff && is_mode;
        res.notify_valid       = notify;
        res.notify_code        = notify ? code : NTF_OFF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_UNKNOWN;
            phase_reg   <= BTN_UNKNOWN;
            start_reg   <= '0;
            count_reg   <= '0;
            pending_reg <= 1'b1;
        end else if (advance) begin
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

endmodule
